### hw/rtl/crc16fr_pkg.sv
// Package for the CRC16 frame receiver: field widths, codes, reset values
// and the byte-wide CRC16-CCITT-FALSE update function.
// No dependencies.
package crc16fr_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned IDLE_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // CRC constants
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Idle counter saturation value
  localparam logic [IDLE_W-1:0] IDLE_MAX = 16'hFFFF;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd170;
  localparam logic [IDLE_W-1:0] TIMEOUT_TICKS_RST = 16'd50;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST   = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD   = 2'd2;

  // Input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EOF     = 1'b1;

  // End-of-frame status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LEN_ERR = 2'd2;

  // One result item
  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data;
    logic [BYTE_W-1:0]   frame_type;
    logic [BYTE_W-1:0]   frame_length;
    logic [STATUS_W-1:0] status;
  } result_t;

  // MSB-first CRC update over one byte, eight shift steps
  function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/crc16_frame_receiver.sv
// CRC16 frame receiver top level: deframer state, CRC check, idle timeout
// and a two-entry output buffer.
// Depends on crc16fr_pkg.

// Takes one item (a received byte or a time tick) per cycle and forwards
// payload bytes cut-through, then one end-of-frame transfer per frame with
// type, length and status (ok, CRC mismatch, or length over max_payload).
// Frames are start byte, type, length, payload, CRC high, CRC low; the CRC
// is CRC16-CCITT-FALSE over type, length and payload. Each item is handled
// in the cycle of its transfer; its result, if any, is registered in the
// output buffer. A two-entry output buffer (output register plus skid)
// keeps the input open while a result waits, so the sustained rate is one
// item per cycle as long as the output side takes one result per cycle.
// Payload already forwarded must be dropped downstream if the status is an
// error. Configuration writes take effect at the next clock edge.
module crc16_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] func
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] out_byte, [15:8] frame_type,
                                  // [23:16] frame_length, [25:24] status
  output logic        out_tuser,  // [0] out_kind
  // Configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC_HI  = 3'd4,
    PH_CRC_LO  = 3'd5
  } phase_t;

  // Configuration registers
  logic [crc16fr_pkg::BYTE_W-1:0] start_byte_r;
  logic [crc16fr_pkg::IDLE_W-1:0] timeout_ticks_r;
  logic [crc16fr_pkg::BYTE_W-1:0] max_payload_r;

  // Frame state
  phase_t                         phase_r,    phase_nxt;
  logic [crc16fr_pkg::BYTE_W-1:0] type_r,     type_nxt;
  logic [crc16fr_pkg::BYTE_W-1:0] len_r,      len_nxt;
  logic [crc16fr_pkg::BYTE_W-1:0] count_r,    count_nxt;
  logic [crc16fr_pkg::CRC_W-1:0]  crc_r,      crc_nxt;
  logic [crc16fr_pkg::BYTE_W-1:0] crc_hi_r,   crc_hi_nxt;
  logic [crc16fr_pkg::IDLE_W-1:0] idle_r,     idle_nxt;

  // Output buffer
  logic                 out_valid_r;
  crc16fr_pkg::result_t out_res_r;
  logic                 skid_valid_r;
  crc16fr_pkg::result_t skid_res_r;

  logic                             in_xfer;
  logic                             pop;
  logic                             push;
  crc16fr_pkg::result_t             res;
  logic [crc16fr_pkg::CRC_W-1:0]    crc_fed;
  logic [crc16fr_pkg::CRC_W-1:0]    crc_got;
  logic [crc16fr_pkg::IDLE_W-1:0]   idle_inc;
  logic [crc16fr_pkg::BYTE_W-1:0]   rx_byte;

  assign rx_byte   = in_tdata;
  assign in_tready = ~skid_valid_r;
  assign in_xfer   = in_tvalid & in_tready;
  assign pop       = out_valid_r & out_tready;

  assign crc_fed  = crc16fr_pkg::crc16_feed(crc_r, rx_byte);
  assign crc_got  = {crc_hi_r, rx_byte};
  assign idle_inc = (idle_r == crc16fr_pkg::IDLE_MAX) ? idle_r
                                                      : idle_r + 1'b1;

  // Next frame state and result for the item in transfer
  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    idle_nxt   = idle_r;
    push       = 1'b0;
    res.kind         = crc16fr_pkg::KIND_PAYLOAD;
    res.data         = rx_byte;
    res.frame_type   = type_r;
    res.frame_length = len_r;
    res.status       = crc16fr_pkg::ST_OK;

    if (in_xfer) begin
      if (in_tuser == crc16fr_pkg::FUNC_TICK) begin
        // Idle tick: abandon the frame once the timeout is exceeded
        idle_nxt = idle_inc;
        if (idle_inc > timeout_ticks_r) begin
          phase_nxt  = PH_HUNT;
          type_nxt   = '0;
          len_nxt    = '0;
          count_nxt  = '0;
          crc_nxt    = crc16fr_pkg::CRC_INIT;
          crc_hi_nxt = '0;
          idle_nxt   = '0;
        end
      end else begin
        idle_nxt = '0;
        unique case (phase_r)
          PH_TYPE: begin
            type_nxt  = rx_byte;
            crc_nxt   = crc_fed;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            len_nxt   = rx_byte;
            crc_nxt   = crc_fed;
            count_nxt = '0;
            phase_nxt = (rx_byte == '0) ? PH_CRC_HI : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            crc_nxt   = crc_fed;
            count_nxt = count_r + 1'b1;
            if (count_nxt >= len_r) begin
              phase_nxt = PH_CRC_HI;
            end
            push = 1'b1;
          end
          PH_CRC_HI: begin
            crc_hi_nxt = rx_byte;
            phase_nxt  = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            // CRC mismatch takes precedence over a length error
            res.kind = crc16fr_pkg::KIND_EOF;
            res.data = '0;
            if (crc_got != crc_r) begin
              res.status = crc16fr_pkg::ST_CRC_ERR;
            end else if (len_r > max_payload_r) begin
              res.status = crc16fr_pkg::ST_LEN_ERR;
            end else begin
              res.status = crc16fr_pkg::ST_OK;
            end
            push       = 1'b1;
            phase_nxt  = PH_HUNT;
            type_nxt   = '0;
            len_nxt    = '0;
            count_nxt  = '0;
            crc_nxt    = crc16fr_pkg::CRC_INIT;
            crc_hi_nxt = '0;
          end
          default: begin
            // Hunting, also for unused phase codes
            if (rx_byte == start_byte_r) begin
              crc_nxt   = crc16fr_pkg::CRC_INIT;
              phase_nxt = PH_TYPE;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        endcase
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      type_r   <= '0;
      len_r    <= '0;
      count_r  <= '0;
      crc_r    <= crc16fr_pkg::CRC_INIT;
      crc_hi_r <= '0;
      idle_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
      idle_r   <= idle_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= crc16fr_pkg::START_BYTE_RST;
      timeout_ticks_r <= crc16fr_pkg::TIMEOUT_TICKS_RST;
      max_payload_r   <= crc16fr_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crc16fr_pkg::REG_START_BYTE:    start_byte_r    <= cfg_data[7:0];
        crc16fr_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        crc16fr_pkg::REG_MAX_PAYLOAD:   max_payload_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_res_r    <= skid_res_r;
        skid_valid_r <= push;
        skid_res_r   <= res;
      end else begin
        out_valid_r  <= push;
        out_res_r    <= res;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
      skid_res_r   <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {{(crc16fr_pkg::OUT_DATA_W - 3*crc16fr_pkg::BYTE_W
                         - crc16fr_pkg::STATUS_W){1'b0}},
                       out_res_r.status, out_res_r.frame_length,
                       out_res_r.frame_type, out_res_r.data};

endmodule

### dv/tb_crc16_frame_receiver.sv
// Self-checking testbench for crc16_frame_receiver: random and directed byte/tick
// streams with a cycle-free predictor of the deframer, CRC and idle timeout.
// Depends on crc16fr_pkg and the crc16_frame_receiver RTL.
module tb_crc16_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LONG_HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS      = 20;

  // One input transfer: byte or tick
  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } rx_item_t;

  // Predictor receive phases
  typedef enum logic [2:0] {
    HUNT_START, GET_TYPE, GET_LENGTH, GET_PAYLOAD, GET_CRC_HI, GET_CRC_LO
  } rx_phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  crc16_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus and expectation stores
  rx_item_t             rx_item_q[$];
  crc16fr_pkg::result_t frame_out_q[$];
  logic [7:0]           frame_body[$];
  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned errors = 0;
  logic        in_fire = 1'b0;

  // Coverage tallies for the summary
  int unsigned ticks_taken = 0;
  int unsigned payload_seen = 0;
  int unsigned eof_seen[3] = '{0, 0, 0};
  int unsigned timeouts_seen = 0;
  int unsigned settings_used = 1;

  // Predictor configuration copy
  logic [7:0]  cur_start;
  logic [15:0] cur_timeout;
  logic [7:0]  cur_max_payload;

  // Predictor frame state
  rx_phase_t   rx_phase;
  logic [7:0]  held_type;
  logic [7:0]  held_len;
  logic [7:0]  payload_cnt;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi_rx;
  logic [15:0] idle_ticks;

  // Generator view of the current settings
  logic [7:0]  gen_start = crc16fr_pkg::START_BYTE_RST;
  int          gen_timeout = int'(crc16fr_pkg::TIMEOUT_TICKS_RST);

  // Sender burst/gap and receiver stall state
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_age = 0;

  // CRC16-CCITT-FALSE, one byte, bit by bit from the MSB
  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ crc16fr_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void clear_frame();
    rx_phase    = HUNT_START;
    held_type   = '0;
    held_len    = '0;
    payload_cnt = '0;
    crc_acc     = crc16fr_pkg::CRC_INIT;
    crc_hi_rx   = '0;
    idle_ticks  = '0;
  endfunction

  // Predict the result (if any) of one accepted item
  task automatic deframe_item(input logic func, input logic [7:0] b);
    crc16fr_pkg::result_t r;
    logic [15:0]          got;
    if (func == crc16fr_pkg::FUNC_TICK) begin
      ticks_taken++;
      if (idle_ticks != crc16fr_pkg::IDLE_MAX) idle_ticks++;
      if (idle_ticks > cur_timeout) begin
        if (rx_phase != HUNT_START) timeouts_seen++;
        clear_frame();
      end
    end else begin
      idle_ticks = '0;
      case (rx_phase)
        GET_TYPE: begin
          held_type = b;
          crc_acc   = crc_ccitt_byte(crc_acc, b);
          rx_phase  = GET_LENGTH;
        end
        GET_LENGTH: begin
          held_len    = b;
          crc_acc     = crc_ccitt_byte(crc_acc, b);
          payload_cnt = '0;
          rx_phase    = (b == 8'd0) ? GET_CRC_HI : GET_PAYLOAD;
        end
        GET_PAYLOAD: begin
          crc_acc     = crc_ccitt_byte(crc_acc, b);
          payload_cnt = payload_cnt + 8'd1;
          if (payload_cnt >= held_len) rx_phase = GET_CRC_HI;
          r = '{kind: crc16fr_pkg::KIND_PAYLOAD, data: b, frame_type: held_type,
                frame_length: held_len, status: crc16fr_pkg::ST_OK};
          frame_out_q.push_back(r);
        end
        GET_CRC_HI: begin
          crc_hi_rx = b;
          rx_phase  = GET_CRC_LO;
        end
        GET_CRC_LO: begin
          got = {crc_hi_rx, b};
          r = '{kind: crc16fr_pkg::KIND_EOF, data: 8'd0, frame_type: held_type,
                frame_length: held_len, status: crc16fr_pkg::ST_OK};
          // CRC error wins over the length error
          if (got != crc_acc) r.status = crc16fr_pkg::ST_CRC_ERR;
          else if (held_len > cur_max_payload) r.status = crc16fr_pkg::ST_LEN_ERR;
          frame_out_q.push_back(r);
          clear_frame();
        end
        default: begin
          if (b == cur_start) begin
            crc_acc  = crc16fr_pkg::CRC_INIT;
            rx_phase = GET_TYPE;
          end else begin
            rx_phase = HUNT_START;
          end
        end
      endcase
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors < 40) begin
        $display("t=%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    end
  endfunction

  // Output check, then prediction of the item taken at this edge
  always @(posedge clk) begin : monitor
    crc16fr_pkg::result_t want;
    if (!rst_n) begin
      cur_start       = crc16fr_pkg::START_BYTE_RST;
      cur_timeout     = crc16fr_pkg::TIMEOUT_TICKS_RST;
      cur_max_payload = crc16fr_pkg::MAX_PAYLOAD_RST;
      clear_frame();
      in_fire = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (frame_out_q.size() == 0) begin
          errors++;
          $display("t=%0t: unexpected result, expected none, actual tdata 0x%0h tuser %0b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = frame_out_q.pop_front();
          check_field("out_kind", want.kind, out_tuser);
          check_field("out_byte", want.data, out_tdata[7:0]);
          check_field("frame_type", want.frame_type, out_tdata[15:8]);
          check_field("frame_length", want.frame_length, out_tdata[23:16]);
          check_field("status", want.status, out_tdata[25:24]);
          check_field("tdata padding", 0, out_tdata[31:26]);
          if (want.kind == crc16fr_pkg::KIND_PAYLOAD) payload_seen++;
          else if (want.status <= crc16fr_pkg::ST_LEN_ERR) eof_seen[want.status]++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          crc16fr_pkg::REG_START_BYTE:    cur_start = cfg_data[7:0];
          crc16fr_pkg::REG_TIMEOUT_TICKS: cur_timeout = cfg_data;
          crc16fr_pkg::REG_MAX_PAYLOAD:   cur_max_payload = cfg_data[7:0];
          default: ;
        endcase
      end
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        deframe_item(in_tuser, in_tdata);
        items_taken++;
      end
    end
  end

  // Input driver: bursts of random length separated by random gaps
  always @(negedge clk) begin : input_driver
    rx_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (rx_item_q.size() > 0) begin
        it = rx_item_q.pop_front();
        in_tuser  <= it.func;
        in_tdata  <= it.data;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: rotating stall pattern, plus long holds on request
  always @(negedge clk) begin : output_receiver
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        pat_age = 48;
        case ($urandom_range(0, 3))
          0:       ready_pat = 16'hFFFF;
          1:       ready_pat = 16'($urandom | $urandom);
          2:       ready_pat = 16'($urandom);
          default: ready_pat = 16'($urandom & $urandom);
        endcase
      end
      pat_age--;
      out_tready <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  task automatic push_rx(input logic func, input logic [7:0] b);
    rx_item_q.push_back('{func: func, data: b});
    items_pushed++;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_rx(crc16fr_pkg::FUNC_TICK, 8'($urandom));
  endtask

  // A few ticks between bytes, never enough to trip the timeout
  task automatic maybe_ticks(input int tick_max);
    if (tick_max > 0 && $urandom_range(0, 4) == 0) push_ticks($urandom_range(1, tick_max));
  endtask

  // Whole frame around frame_body, optionally with a corrupted CRC
  task automatic push_frame(input logic [7:0] ftype, input logic bad_crc, input int tick_max);
    logic [15:0] crc;
    logic [7:0]  len;
    len = 8'(frame_body.size());
    crc = crc_ccitt_byte(crc_ccitt_byte(crc16fr_pkg::CRC_INIT, ftype), len);
    foreach (frame_body[i]) crc = crc_ccitt_byte(crc, frame_body[i]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    push_rx(crc16fr_pkg::FUNC_BYTE, gen_start);
    maybe_ticks(tick_max);
    push_rx(crc16fr_pkg::FUNC_BYTE, ftype);
    maybe_ticks(tick_max);
    push_rx(crc16fr_pkg::FUNC_BYTE, len);
    foreach (frame_body[i]) begin
      maybe_ticks(tick_max);
      push_rx(crc16fr_pkg::FUNC_BYTE, frame_body[i]);
    end
    maybe_ticks(tick_max);
    push_rx(crc16fr_pkg::FUNC_BYTE, crc[15:8]);
    maybe_ticks(tick_max);
    push_rx(crc16fr_pkg::FUNC_BYTE, crc[7:0]);
  endtask

  // One random unit: mostly good frames, then noise, idle time, cut frames
  task automatic gen_unit();
    int sel, n, base, cut;
    logic [7:0] b;
    sel = $urandom_range(0, 99);
    frame_body.delete();
    if (sel < 70) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      repeat (n) frame_body.push_back(8'($urandom));
      push_frame(8'($urandom), $urandom_range(0, 6) == 0,
                 (gen_timeout < 4) ? gen_timeout : 4);
    end else if (sel < 88 && sel >= 80) begin
      push_ticks($urandom_range(1, (gen_timeout < 40) ? gen_timeout + 1 : 40));
    end else if (sel >= 88 && gen_timeout <= 40) begin
      // Frame cut short, then enough idle time to abandon it
      n = $urandom_range(1, 6);
      repeat (n) frame_body.push_back(8'($urandom));
      base = rx_item_q.size();
      push_frame(8'($urandom), 1'b0, 0);
      cut = $urandom_range(1, n + 4);
      while (rx_item_q.size() > base + cut) begin
        void'(rx_item_q.pop_back());
        items_pushed--;
      end
      push_ticks(gen_timeout + 1);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == gen_start) b = b ^ 8'h01;
        push_rx(crc16fr_pkg::FUNC_BYTE, b);
      end
    end
  endtask

  // Everything sent, taken and answered, then the pipeline left to settle
  task automatic wait_idle();
    while (items_taken != items_pushed || frame_out_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] sb, input logic [15:0] tmo, input logic [7:0] mp);
    cfg_we    <= 1'b1;
    cfg_index <= crc16fr_pkg::REG_START_BYTE;
    cfg_data  <= {8'd0, sb};
    @(negedge clk);
    cfg_index <= crc16fr_pkg::REG_TIMEOUT_TICKS;
    cfg_data  <= tmo;
    @(negedge clk);
    cfg_index <= crc16fr_pkg::REG_MAX_PAYLOAD;
    cfg_data  <= {8'd0, mp};
    @(negedge clk);
    cfg_we    <= 1'b0;
    gen_start   = sb;
    gen_timeout = int'(tmo);
    settings_used++;
  endtask

  // Run limit
  initial begin
    #5ms;
    $display("Timeout: %0d of %0d items taken, %0d results outstanding",
             items_taken, items_pushed, frame_out_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Test sequence
  initial begin : stimulus
    logic [7:0]  sb, mp;
    logic [15:0] tmo;
    int unsigned phase_start;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: hunt drops, zero length, start byte as data, bad CRC, ticks
    push_rx(crc16fr_pkg::FUNC_BYTE, 8'h00);
    push_rx(crc16fr_pkg::FUNC_BYTE, 8'hFF);
    push_frame(8'h00, 1'b0, 0);
    frame_body = '{crc16fr_pkg::START_BYTE_RST, 8'hFF};
    push_frame(crc16fr_pkg::START_BYTE_RST, 1'b0, 0);
    frame_body = '{8'h00};
    push_frame(8'hFF, 1'b1, 0);
    push_rx(crc16fr_pkg::FUNC_TICK, 8'h00);
    push_rx(crc16fr_pkg::FUNC_TICK, 8'hFF);
    wait_idle();

    // Register settings: low extremes, high extremes, then random ones
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin sb = 8'h00; tmo = 16'd1;     mp = 8'd0;   end
        1: begin sb = 8'hFF; tmo = 16'hFFFF;  mp = 8'hFF;  end
        default: begin
          sb  = 8'($urandom);
          tmo = 16'($urandom_range(2, 30));
          mp  = 8'($urandom_range(0, 12));
        end
      endcase
      set_config(sb, tmo, mp);
      if (p == 1) begin
        // Longest frame while the receiver holds off; then drain fully
        frame_body.delete();
        repeat (255) frame_body.push_back(8'($urandom));
        hold_requests++;
        push_frame(8'($urandom), 1'b0, 0);
        wait_idle();
      end
      phase_start = items_pushed;
      while (items_pushed - phase_start < PHASE_ITEMS) gen_unit();
      wait_idle();
    end

    repeat (10) @(negedge clk);
    $display("Covered %0d items (%0d ticks) over %0d register settings, %0d frames cut by timeout",
             items_taken, ticks_taken, settings_used, timeouts_seen);
    $display("Checked %0d payload bytes and frame ends: %0d ok, %0d CRC error, %0d too long",
             payload_seen, eof_seen[0], eof_seen[1], eof_seen[2]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/crc16fr_pkg.sv
hw/rtl/crc16_frame_receiver.sv
dv/tb_crc16_frame_receiver.sv
